>>> hdl/assert_macros.svh
// assertion macros used by the cusum_jump_detector rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CJD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cjd assertion failed");

// condition must never be seen at a clock edge outside reset
`define CJD_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("cjd forbidden condition seen");

`endif

>>> hdl/cjd_pkg.sv
// shared types and constants of the cusum jump detector
// no dependencies
`timescale 1ns / 1ps

package cjd_pkg;

  // default widths of sample, accumulators and count
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF    = 32;
  localparam int COUNT_BITS_DEF  = 16;

  // register widths and reset values
  localparam int ALPHA_W = 31;
  localparam int HD_W    = 16;
  localparam int MODE_W  = 2;
  localparam int JUMP_W  = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(51);
  localparam logic [HD_W-1:0]    HD_RST    = HD_W'(26);

  // apb port geometry
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_ALPHA      = 2'd0,
    REG_HALF_DELTA = 2'd1,
    REG_TEST_MODE  = 2'd2
  } reg_e;

  // test mode codes, the unused code runs the both-way test
  typedef enum logic [MODE_W-1:0] {
    MODE_DOWN = 2'd0,
    MODE_UP   = 2'd1,
    MODE_BOTH = 2'd2
  } mode_e;

  // result codes
  typedef enum logic [JUMP_W-1:0] {
    JUMP_NONE = 2'd0,
    JUMP_DOWN = 2'd1,
    JUMP_UP   = 2'd2
  } jump_e;

endpackage

>>> hdl/cjd_sample_if.sv
// input channel carrying one signed sample per transfer
// depends on cjd_pkg
`timescale 1ns / 1ps

interface cjd_sample_if #(
  parameter int SAMPLE_BITS = cjd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> hdl/cjd_jump_if.sv
// output channel carrying one jump code per transfer
// depends on cjd_pkg
`timescale 1ns / 1ps

interface cjd_jump_if;
  logic                        valid;
  logic                        ready;
  logic [cjd_pkg::JUMP_W-1:0]  jump;

  modport source (output valid, output jump, input ready);
  modport sink   (input valid, input jump, output ready);
endinterface

>>> hdl/cjd_div.sv
// bit-serial restoring divider, signed dividend by unsigned count,
// quotient truncated toward zero; depends on cjd_pkg for default widths
`timescale 1ns / 1ps

module cjd_div #(
  parameter int SAMPLE_BITS = cjd_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = cjd_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [SAMPLE_BITS:0] dividend_i,
  input  logic [COUNT_BITS-1:0]       divisor_i,
  output logic                        done_o,
  output logic signed [SAMPLE_BITS:0] quot_o
);

  localparam int CW = $clog2(SAMPLE_BITS + 1);

  logic                   busy_q;
  logic                   done_q;
  logic                   neg_q;
  logic [CW-1:0]          cnt_q;
  logic [SAMPLE_BITS-1:0] dvd_q;
  logic [COUNT_BITS-1:0]  rem_q;
  logic [COUNT_BITS-1:0]  dvs_q;

  logic [SAMPLE_BITS:0]   mag;
  logic [COUNT_BITS:0]    trial;
  logic [COUNT_BITS:0]    diff;
  logic                   qbit;

  // magnitude of the dividend
  assign mag = dividend_i[SAMPLE_BITS] ? (~dividend_i + 1'b1) : dividend_i;

  // one quotient bit per cycle
  assign trial = {rem_q, dvd_q[SAMPLE_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = ~diff[COUNT_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(SAMPLE_BITS);
        neg_q  <= dividend_i[SAMPLE_BITS];
        dvd_q  <= mag[SAMPLE_BITS-1:0];
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        dvd_q <= {dvd_q[SAMPLE_BITS-2:0], qbit};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // restore the sign of the quotient
  assign done_o = done_q;
  assign quot_o = neg_q ? $signed(~{1'b0, dvd_q} + 1'b1) : $signed({1'b0, dvd_q});

endmodule

>>> hdl/cusum_jump_detector.sv
// cusum jump detector top level: apb registers, sequencer, accumulators
// depends on cjd_pkg, cjd_sample_if, cjd_jump_if, cjd_div, assert_macros.svh
// sequence: prep, sum, peak and test states, then the result step; the bit-serial
//   divider runs between test and result when no jump is found and both gaps are zero
// throughput: one item at a time, the next input is taken once the result register loads
// reset: asynchronous, clears count, mean and all sums, registers to defaults
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cusum_jump_detector #(
  parameter int SAMPLE_BITS = cjd_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = cjd_pkg::ACC_BITS_DEF,
  parameter int COUNT_BITS  = cjd_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  cjd_sample_if.sink                  smp_i,
  cjd_jump_if.source                  jmp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cjd_pkg::APB_AW-1:0]  paddr,
  input  logic [cjd_pkg::APB_DW-1:0]  pwdata,
  output logic [cjd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int AW = cjd_pkg::ALPHA_W;
  localparam int HW = cjd_pkg::HD_W;
  // width of sample difference plus or minus half delta
  localparam int PW = ((SAMPLE_BITS + 1 > HW + 1) ? SAMPLE_BITS + 1 : HW + 1) + 1;
  // width of accumulator update before saturation
  localparam int EW = ((ACC_BITS > PW) ? ACC_BITS : PW) + 1;
  // width of gap to threshold compare
  localparam int GW = ((ACC_BITS + 1 > AW) ? ACC_BITS + 1 : AW) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SUM,
    ST_PEAK,
    ST_TEST,
    ST_DIV,
    ST_OUT
  } state_e;

  // configuration registers
  logic [AW-1:0]              alpha_q;
  logic [HW-1:0]              hd_q;
  logic [cjd_pkg::MODE_W-1:0] mode_q;

  // sequencer and datapath registers
  state_e                        state_q;
  logic [COUNT_BITS-1:0]         n_q;
  logic signed [SAMPLE_BITS-1:0] m_q;
  logic signed [SAMPLE_BITS-1:0] s_q;
  logic signed [SAMPLE_BITS:0]   d_q;
  logic signed [PW-1:0]          dp_q;
  logic signed [PW-1:0]          dm_q;
  logic signed [ACC_BITS-1:0]    sd_q;
  logic signed [ACC_BITS-1:0]    md_q;
  logic signed [ACC_BITS-1:0]    su_q;
  logic signed [ACC_BITS-1:0]    mu_q;
  cjd_pkg::jump_e                jump_q;
  logic                          div_start_q;
  logic                          out_valid_q;
  logic [cjd_pkg::JUMP_W-1:0]    out_jump_q;

  logic                          cfg_wr;
  logic                          do_dn;
  logic                          do_up;
  logic                          both;
  logic signed [SAMPLE_BITS:0]   d_d;
  logic signed [PW-1:0]          dp_d;
  logic signed [PW-1:0]          dm_d;
  logic [EW-1:0]                 sum_dn_ext;
  logic [EW-1:0]                 sum_up_ext;
  logic signed [ACC_BITS-1:0]    sd_d;
  logic signed [ACC_BITS-1:0]    su_d;
  logic [ACC_BITS:0]             gap_dn;
  logic [ACC_BITS:0]             gap_up;
  logic                          gaps_zero;
  cjd_pkg::jump_e                jump_d;
  logic                          div_done;
  logic signed [SAMPLE_BITS:0]   div_quot;
  logic [SAMPLE_BITS:0]          m_sum;
  logic                          out_load;

  // saturate an extended sum to the accumulator range
  function automatic logic [ACC_BITS-1:0] sat_acc(input logic [EW-1:0] v);
    logic [ACC_BITS-1:0] hi;
    logic [ACC_BITS-1:0] lo;
    hi = {1'b0, {(ACC_BITS-1){1'b1}}};
    lo = {1'b1, {(ACC_BITS-1){1'b0}}};
    if (!v[EW-1] && (|v[EW-2:ACC_BITS-1])) begin
      return hi;
    end else if (v[EW-1] && !(&v[EW-2:ACC_BITS-1])) begin
      return lo;
    end else begin
      return v[ACC_BITS-1:0];
    end
  endfunction

  // apb register access, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      cjd_pkg::REG_ALPHA:      prdata = cjd_pkg::APB_DW'(alpha_q);
      cjd_pkg::REG_HALF_DELTA: prdata = cjd_pkg::APB_DW'(hd_q);
      cjd_pkg::REG_TEST_MODE:  prdata = cjd_pkg::APB_DW'(mode_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= cjd_pkg::ALPHA_RST;
      hd_q    <= cjd_pkg::HD_RST;
      mode_q  <= cjd_pkg::MODE_BOTH;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        cjd_pkg::REG_ALPHA:      alpha_q <= pwdata[AW-1:0];
        cjd_pkg::REG_HALF_DELTA: hd_q    <= pwdata[HW-1:0];
        cjd_pkg::REG_TEST_MODE:  mode_q  <= pwdata[cjd_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // tested directions
  assign do_dn = (mode_q != cjd_pkg::MODE_UP);
  assign do_up = (mode_q != cjd_pkg::MODE_DOWN);
  assign both  = do_dn & do_up;

  // sample minus mean; the first sample after a clear is the mean
  assign d_d = (n_q == '0) ? '0
             : ($signed({smp_i.sample[SAMPLE_BITS-1], smp_i.sample})
                - $signed({m_q[SAMPLE_BITS-1], m_q}));

  // difference plus and minus half delta
  assign dp_d = $signed({{(PW-SAMPLE_BITS-1){d_q[SAMPLE_BITS]}}, d_q})
              + $signed({{(PW-HW){1'b0}}, hd_q});
  assign dm_d = $signed({{(PW-SAMPLE_BITS-1){d_q[SAMPLE_BITS]}}, d_q})
              - $signed({{(PW-HW){1'b0}}, hd_q});

  // saturating accumulator updates
  assign sum_dn_ext = {{(EW-ACC_BITS){sd_q[ACC_BITS-1]}}, sd_q}
                    + {{(EW-PW){dp_q[PW-1]}}, dp_q};
  assign sum_up_ext = {{(EW-ACC_BITS){su_q[ACC_BITS-1]}}, su_q}
                    + {{(EW-PW){dm_q[PW-1]}}, dm_q};
  assign sd_d = $signed(sat_acc(sum_dn_ext));
  assign su_d = $signed(sat_acc(sum_up_ext));

  // gaps against their peaks, never negative
  assign gap_dn = {md_q[ACC_BITS-1], md_q} - {sd_q[ACC_BITS-1], sd_q};
  assign gap_up = {su_q[ACC_BITS-1], su_q} - {mu_q[ACC_BITS-1], mu_q};
  assign gaps_zero = (md_q == sd_q) && (su_q == mu_q);

  // jump decision, downward test first
  always_comb begin
    jump_d = cjd_pkg::JUMP_NONE;
    if (do_dn && ({{(GW-ACC_BITS-1){1'b0}}, gap_dn} > {{(GW-AW){1'b0}}, alpha_q})) begin
      jump_d = cjd_pkg::JUMP_DOWN;
    end else if (do_up
                 && ({{(GW-ACC_BITS-1){1'b0}}, gap_up} > {{(GW-AW){1'b0}}, alpha_q})) begin
      jump_d = cjd_pkg::JUMP_UP;
    end
  end

  // mean plus truncated quotient
  assign m_sum = {m_q[SAMPLE_BITS-1], m_q} + div_quot;

  // result register loads once the previous transfer is gone
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || jmp_o.ready);

  cjd_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (d_q),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // sequencer with datapath state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      m_q         <= '0;
      s_q         <= '0;
      d_q         <= '0;
      dp_q        <= '0;
      dm_q        <= '0;
      sd_q        <= '0;
      md_q        <= '0;
      su_q        <= '0;
      mu_q        <= '0;
      jump_q      <= cjd_pkg::JUMP_NONE;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_jump_q  <= cjd_pkg::JUMP_NONE;
    end else begin
      div_start_q <= (state_q == ST_TEST) && (jump_d == cjd_pkg::JUMP_NONE) && gaps_zero;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && jmp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (smp_i.valid) begin
            s_q     <= smp_i.sample;
            d_q     <= d_d;
            n_q     <= (&n_q) ? n_q : n_q + 1'b1;
            if (n_q == '0) begin
              m_q <= smp_i.sample;
            end
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          dp_q    <= dp_d;
          dm_q    <= dm_d;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          if (do_dn) begin
            sd_q <= sd_d;
          end
          if (do_up) begin
            su_q <= su_d;
          end
          state_q <= ST_PEAK;
        end
        ST_PEAK: begin
          if (do_dn && (sd_q > md_q)) begin
            md_q <= sd_q;
          end
          if (do_up && (su_q < mu_q)) begin
            mu_q <= su_q;
          end
          state_q <= ST_TEST;
        end
        ST_TEST: begin
          jump_q <= jump_d;
          if (jump_d != cjd_pkg::JUMP_NONE) begin
            n_q <= '0;
            if (both) begin
              sd_q <= '0;
              md_q <= '0;
              su_q <= '0;
              mu_q <= '0;
              m_q  <= s_q;
            end else if (jump_d == cjd_pkg::JUMP_DOWN) begin
              sd_q <= '0;
              md_q <= '0;
            end else begin
              su_q <= '0;
              mu_q <= '0;
            end
            state_q <= ST_OUT;
          end else if (gaps_zero) begin
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            m_q     <= $signed(m_sum[SAMPLE_BITS-1:0]);
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_jump_q <= jump_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // channel outputs
  assign smp_i.ready = (state_q == ST_IDLE);
  assign jmp_o.valid = out_valid_q;
  assign jmp_o.jump  = out_jump_q;

  // peaks never fall behind their sums once the peak step is done
  `CJD_NEVER(a_peak_dn, clk_i, rst_ni, (state_q != ST_PEAK) && (sd_q > md_q))
  `CJD_NEVER(a_peak_up, clk_i, rst_ni, (state_q != ST_PEAK) && (su_q < mu_q))
  // a jump clears the sample count
  `CJD_ASSERT(a_jump_clr, clk_i, rst_ni,
              ((state_q == ST_TEST) && (jump_d != cjd_pkg::JUMP_NONE)) |=> (n_q == '0))
  // a new result only comes from the result step
  `CJD_ASSERT(a_out_src, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_OUT))

endmodule

>>> verif/testbench.sv
// self-checking testbench for the cusum jump detector
// depends on cjd_pkg, cjd_sample_if, cjd_jump_if and the cusum_jump_detector rtl
`timescale 1ns / 1ps

module testbench;

  localparam int SW = cjd_pkg::SAMPLE_BITS_DEF;
  localparam int AW = cjd_pkg::ACC_BITS_DEF;
  localparam int CW = cjd_pkg::COUNT_BITS_DEF;
  localparam int NUM_REGS = 3;
  localparam int REG_SPARE = 3;  // first index past the register list

  localparam longint ACC_HI = (longint'(1) << (AW - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};
  localparam logic [cjd_pkg::ALPHA_W-1:0] ALPHA_MAX = {cjd_pkg::ALPHA_W{1'b1}};
  localparam logic [cjd_pkg::HD_W-1:0] HD_MAX = {cjd_pkg::HD_W{1'b1}};

  localparam int SETTLE_CYCLES = 30;
  localparam int QUIET_LIMIT = 500;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [cjd_pkg::APB_AW-1:0] paddr;
  logic [cjd_pkg::APB_DW-1:0] pwdata;
  logic [cjd_pkg::APB_DW-1:0] prdata;
  logic pready;

  cjd_sample_if smp ();
  cjd_jump_if jmp ();

  cusum_jump_detector DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .smp_i   (smp),
    .jmp_o   (jmp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // detector model: registers and state
  logic [cjd_pkg::ALPHA_W-1:0] alpha_q = cjd_pkg::ALPHA_RST;
  logic [cjd_pkg::HD_W-1:0] hd_q = cjd_pkg::HD_RST;
  logic [cjd_pkg::MODE_W-1:0] mode_q = cjd_pkg::MODE_BOTH;
  logic [CW-1:0] count_q = '0;
  logic signed [SW-1:0] mean_q = '0;
  logic signed [AW-1:0] sdown_q = '0;
  logic signed [AW-1:0] maxdown_q = '0;
  logic signed [AW-1:0] sup_q = '0;
  logic signed [AW-1:0] minup_q = '0;

  cjd_pkg::jump_e expected_jumps[$];
  cjd_pkg::jump_e last_jump = cjd_pkg::JUMP_NONE;
  bit idle_on = 1'b1;

  int samples_sent = 0;
  int results_seen = 0;
  int down_jumps = 0;
  int up_jumps = 0;
  int writes_done = 0;
  int mismatch_count = 0;

  function automatic logic signed [AW-1:0] clip_acc(input longint v);
    if (v > ACC_HI) return AW'(ACC_HI);
    if (v < ACC_LO) return AW'(ACC_LO);
    return AW'(v);
  endfunction

  function automatic logic signed [SW-1:0] to_sample(input int v);
    if (v > int'(S_MAX)) return S_MAX;
    if (v < int'(S_MIN)) return S_MIN;
    return SW'(v);
  endfunction

  // one sample through the cusum test, returns the jump code
  function automatic cjd_pkg::jump_e cusum_step(input logic signed [SW-1:0] s);
    longint sv;
    longint hd;
    longint alpha;
    longint quo;
    bit do_down;
    bit do_up;
    cjd_pkg::jump_e j;
    sv = s;
    hd = hd_q;
    alpha = alpha_q;
    do_down = (mode_q != cjd_pkg::MODE_UP);
    do_up = (mode_q != cjd_pkg::MODE_DOWN);
    j = cjd_pkg::JUMP_NONE;
    if (count_q != COUNT_MAX) count_q = count_q + 1'b1;
    if (count_q == 1) mean_q = s;
    if (do_down) begin
      sdown_q = clip_acc(longint'(sdown_q) + sv - longint'(mean_q) + hd);
      if (sdown_q > maxdown_q) maxdown_q = sdown_q;
    end
    if (do_up) begin
      sup_q = clip_acc(longint'(sup_q) + sv - longint'(mean_q) - hd);
      if (sup_q < minup_q) minup_q = sup_q;
    end
    if (do_down && (longint'(maxdown_q) - longint'(sdown_q)) > alpha) begin
      j = cjd_pkg::JUMP_DOWN;
    end else if (do_up && (longint'(sup_q) - longint'(minup_q)) > alpha) begin
      j = cjd_pkg::JUMP_UP;
    end
    // mean follows the samples only while both gaps are closed
    if (maxdown_q == sdown_q && sup_q == minup_q) begin
      quo = (sv - longint'(mean_q)) / longint'(count_q);
      mean_q = SW'(longint'(mean_q) + quo);
    end
    if (j != cjd_pkg::JUMP_NONE) begin
      count_q = '0;
      if (do_down && do_up) begin
        sdown_q = '0;
        maxdown_q = '0;
        sup_q = '0;
        minup_q = '0;
        mean_q = s;
      end else if (j == cjd_pkg::JUMP_DOWN) begin
        sdown_q = '0;
        maxdown_q = '0;
      end else begin
        sup_q = '0;
        minup_q = '0;
      end
    end
    return j;
  endfunction

  function automatic logic [cjd_pkg::APB_DW-1:0] reg_model(input int idx);
    case (idx)
      cjd_pkg::REG_ALPHA:      return cjd_pkg::APB_DW'(alpha_q);
      cjd_pkg::REG_HALF_DELTA: return cjd_pkg::APB_DW'(hd_q);
      cjd_pkg::REG_TEST_MODE:  return cjd_pkg::APB_DW'(mode_q);
      default:                 return '0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // apb read, compared with the model register
  task automatic check_register(input int idx);
    logic [cjd_pkg::APB_DW-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= cjd_pkg::APB_AW'(idx * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== reg_model(idx)) begin
      report_mismatch($sformatf("register %0d reads %0h, expected %0h", idx, got,
                                reg_model(idx)));
    end
  endtask

  // apb write, model updated at the access edge
  task automatic reg_write(input int idx, input logic [cjd_pkg::APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= cjd_pkg::APB_AW'(idx * 4);
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      cjd_pkg::REG_ALPHA:      alpha_q = data[cjd_pkg::ALPHA_W-1:0];
      cjd_pkg::REG_HALF_DELTA: hd_q = data[cjd_pkg::HD_W-1:0];
      cjd_pkg::REG_TEST_MODE:  mode_q = data[cjd_pkg::MODE_W-1:0];
      default: ;
    endcase
    writes_done++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    if (idx < NUM_REGS) check_register(idx);
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_results_done();
    smp.valid <= 1'b0;
    while (expected_jumps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [cjd_pkg::APB_DW-1:0] alpha_raw,
                            input logic [cjd_pkg::APB_DW-1:0] hd_raw,
                            input logic [cjd_pkg::APB_DW-1:0] mode_raw);
    wait_results_done();
    reg_write(cjd_pkg::REG_ALPHA, alpha_raw);
    reg_write(cjd_pkg::REG_HALF_DELTA, hd_raw);
    reg_write(cjd_pkg::REG_TEST_MODE, mode_raw);
  endtask

  // one sample transfer; the expected jump is worked out at acceptance
  task automatic send_sample(input logic signed [SW-1:0] s);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp.valid <= 1'b1;
    smp.sample <= s;
    do @(posedge clk_i); while (smp.ready !== 1'b1);
    last_jump = cusum_step(s);
    expected_jumps.push_back(last_jump);
    samples_sent++;
    if (last_jump == cjd_pkg::JUMP_DOWN) down_jumps++;
    if (last_jump == cjd_pkg::JUMP_UP) up_jumps++;
  endtask

  // force a both-way jump so that count, sums and mean start from a known point
  task automatic clear_state();
    int tries;
    set_config('0, '0, cjd_pkg::MODE_BOTH);
    tries = 0;
    do begin
      send_sample((tries % 2 == 0) ? to_sample(4096) : to_sample(-4096));
      tries++;
    end while (last_jump == cjd_pkg::JUMP_NONE && tries < 16);
  endtask

  task automatic test_default_detection();
    check_register(cjd_pkg::REG_ALPHA);
    check_register(cjd_pkg::REG_HALF_DELTA);
    check_register(cjd_pkg::REG_TEST_MODE);
    send_sample('0);
    send_sample('0);
    send_sample('0);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MIN);
    send_sample('0);
  endtask

  task automatic test_register_access();
    wait_results_done();
    // bits above each register width are dropped, mode lands on the unused code
    reg_write(cjd_pkg::REG_ALPHA, 32'hFFFF_FFFF);
    reg_write(cjd_pkg::REG_HALF_DELTA, 32'hFFFF_FFFF);
    reg_write(cjd_pkg::REG_TEST_MODE, 32'hFFFF_FFFF);
    reg_write(cjd_pkg::REG_ALPHA, 32'h8000_0000);
    reg_write(cjd_pkg::REG_HALF_DELTA, 32'h5A5A_0000);
    reg_write(cjd_pkg::REG_TEST_MODE, 32'hFFFF_FFFC);
    // write past the register list changes nothing
    reg_write(REG_SPARE, 32'h1234_5678);
    check_register(cjd_pkg::REG_ALPHA);
    check_register(cjd_pkg::REG_HALF_DELTA);
    check_register(cjd_pkg::REG_TEST_MODE);
  endtask

  task automatic test_each_mode();
    int m;
    for (m = 0; m < 4; m++) begin
      set_config(100, 10, cjd_pkg::APB_DW'(m));
      send_sample('0);
      send_sample('0);
      send_sample(to_sample(-3000));
      send_sample(to_sample(3000));
      send_sample(to_sample(3000));
    end
  endtask

  // level segments with noise and steps between them, some raw noise
  task automatic test_random();
    int phase;
    int sent;
    int len;
    int amp;
    int level;
    int jog;
    logic [cjd_pkg::ALPHA_W-1:0] a;
    logic [cjd_pkg::HD_W-1:0] h;
    clear_state();
    for (phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin
          a = '0;
          h = '0;
        end
        1: begin
          a = ALPHA_MAX;
          h = HD_MAX;
        end
        default: begin
          a = ($urandom_range(0, 7) == 0) ? cjd_pkg::ALPHA_W'($urandom)
                                          : cjd_pkg::ALPHA_W'($urandom_range(0, 3000));
          h = ($urandom_range(0, 7) == 0) ? cjd_pkg::HD_W'($urandom)
                                          : cjd_pkg::HD_W'($urandom_range(0, 600));
        end
      endcase
      set_config({1'($urandom), a}, {16'($urandom), h}, {30'($urandom), 2'(phase % 4)});
      idle_on = (phase % 3 != 2);
      level = $urandom_range(0, 16000) - 8000;
      sent = 0;
      while (sent < 50) begin
        if ($urandom_range(0, 9) < 8) begin
          len = $urandom_range(3, 14);
          amp = $urandom_range(0, 64);
          repeat (len) send_sample(to_sample(level + $urandom_range(0, 2 * amp) - amp));
          sent += len;
          jog = $urandom_range(0, 6000);
          level = ($urandom_range(0, 1) == 1) ? level + jog : level - jog;
          if (level > 30000 || level < -30000) level = 0;
        end else begin
          len = $urandom_range(1, 3);
          repeat (len) send_sample(SW'($urandom));
          sent += len;
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // result side: random stall before each transfer while idle gaps are on
  initial begin : result_sink
    int stall;
    jmp.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        jmp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      jmp.ready <= 1'b1;
      do @(posedge clk_i); while (jmp.valid !== 1'b1);
    end
  end

  // compare each result transfer with the oldest expected jump
  always @(posedge clk_i) begin : jump_checker
    cjd_pkg::jump_e want;
    if (rst_ni === 1'b1 && jmp.valid === 1'b1 && jmp.ready === 1'b1) begin
      results_seen++;
      if (expected_jumps.size() == 0) begin
        report_mismatch($sformatf("jump result %0d with none expected", jmp.jump));
      end else begin
        want = expected_jumps.pop_front();
        if (jmp.jump !== want) begin
          report_mismatch($sformatf("jump %0d, expected %0d", jmp.jump, want));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((smp.valid === 1'b1 && smp.ready === 1'b1) ||
          (jmp.valid === 1'b1 && jmp.ready === 1'b1) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding", QUIET_LIMIT,
             expected_jumps.size());
    $display("status: fail");
    $finish;
  end

  initial begin : main
    smp.valid <= 1'b0;
    smp.sample <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_detection();
    test_register_access();
    test_each_mode();
    test_random();
    wait_results_done();

    $display("covered %0d samples, %0d results, %0d down and %0d up jumps, %0d writes",
             samples_sent, results_seen, down_jumps, up_jumps, writes_done);
    $display("every test mode incl. the spare code, masked and stray register writes, steps");
    if (mismatch_count == 0 && expected_jumps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
